// File: rtl/core/einr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// einr_pkg: shared types and constants for the exact integer nth root block
// Controller states, datapath command and status groups, multiplier chunking.
// ----------------------------------------------------------------------------
package einr_pkg;

	localparam int ROOT_W = 32;
	localparam int MUL_CHUNK_W = 32;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RANGE,
		ST_TEST,
		ST_WAIT_ACC,
		ST_SHIFT,
		ST_WAIT_BASE,
		ST_FINAL,
		ST_FINISH
	} state_t;

	typedef enum logic {
		MUL_SEL_ACC,
		MUL_SEL_BASE
	} mul_sel_t;

	typedef struct packed {
		logic     load;
		logic     setup;
		logic     mul_start;
		mul_sel_t mul_sel;
		logic     acc_wr;
		logic     base_wr;
		logic     e_shift;
		logic     go_left;
		logic     go_right;
		logic     set_hit;
		logic     out_load;
	} dp_cmd_t;

	typedef struct packed {
		logic range_ok;
		logic e_zero;
		logic e_lsb;
		logic e_last;
		logic prod_gt;
		logic acc_eq;
		logic mid_eq_hi;
		logic mul_done;
	} dp_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/exact_integer_nth_root.sv
`default_nettype none
// ----------------------------------------------------------------------------
// exact_integer_nth_root: exact integer nth root by bisection
// Bisects 1..radicand; each candidate is raised to the exponent by
// square-and-multiply with an early exit once a product exceeds the radicand.
//
// Channel   Direction  Handshake              Payload
// input     in         in_valid / in_stall    exponent, radicand
// output    out        out_valid / out_stall  root, found
//
// One item at a time. Each bisection step examines the exponent bits, with up
// to two multiplies per exponent bit; an item takes at most VALUE_WIDTH such
// steps. All multiplies use the single shared multiplier in the datapath.
// A finished result waits in the output register while the next item is taken.
// Reset clears the controller and the result valid flag.
// ----------------------------------------------------------------------------
module exact_integer_nth_root #(
	parameter int VALUE_WIDTH    = 32,
	parameter int EXPONENT_WIDTH = 8
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire logic                      in_valid,
	output logic                           in_stall,
	input  wire logic [EXPONENT_WIDTH-1:0] exponent,
	input  wire logic [VALUE_WIDTH-1:0]    radicand,
	output logic                           out_valid,
	input  wire logic                      out_stall,
	output logic [einr_pkg::ROOT_W-1:0]    root,
	output logic                           found
);
	import einr_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	einr_ctrl u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.stat(stat),
		.cmd(cmd)
	);

	einr_dp #(
		.VALUE_WIDTH(VALUE_WIDTH),
		.EXPONENT_WIDTH(EXPONENT_WIDTH)
	) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.exponent(exponent),
		.radicand(radicand),
		.stat(stat),
		.root(root),
		.found(found)
	);

endmodule

`default_nettype wire

// File: rtl/core/einr_mul.sv
`default_nettype none
// ----------------------------------------------------------------------------
// einr_mul: multi-cycle unsigned multiplier
// Forms the full product from 32 by 32 bit partial products, one per cycle,
// each registered before it is accumulated.
// ----------------------------------------------------------------------------
module einr_mul #(
	parameter int W = 32
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             start,
	input  wire logic [W-1:0]     a,
	input  wire logic [W-1:0]     b,
	output logic                  done,
	output logic [2*W-1:0]        product
);
	import einr_pkg::*;

	localparam int NC = (W + MUL_CHUNK_W - 1) / MUL_CHUNK_W;
	localparam int PW = NC * MUL_CHUNK_W;
	localparam int IW = (NC > 1) ? $clog2(NC) : 1;

	logic [PW-1:0]            a_q;
	logic [PW-1:0]            b_q;
	logic [2*PW-1:0]          acc_q;
	logic [IW-1:0]            i_q;
	logic [IW-1:0]            j_q;
	logic                     busy_q;
	logic                     done_q;
	logic [2*MUL_CHUNK_W-1:0] prod_s1;
	logic [IW:0]              sum_s1;
	logic                     pv_s1;
	logic                     last_s1;
	logic [MUL_CHUNK_W-1:0]   ca;
	logic [MUL_CHUNK_W-1:0]   cb;
	logic                     last;
	logic [2*PW-1:0]          pp_ext;

	assign ca = a_q[MUL_CHUNK_W*i_q +: MUL_CHUNK_W];
	assign cb = b_q[MUL_CHUNK_W*j_q +: MUL_CHUNK_W];
	assign last = (i_q == IW'(NC - 1)) && (j_q == IW'(NC - 1));
	assign pp_ext = (2*PW)'(prod_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			pv_s1 <= 1'b0;
			last_s1 <= 1'b0;
			i_q <= '0;
			j_q <= '0;
		end else begin
			done_q <= pv_s1 && last_s1;
			pv_s1 <= busy_q;
			last_s1 <= busy_q && last;
			if (start) begin
				busy_q <= 1'b1;
				i_q <= '0;
				j_q <= '0;
			end else if (busy_q) begin
				if (last) begin
					busy_q <= 1'b0;
				end else if (j_q == IW'(NC - 1)) begin
					j_q <= '0;
					i_q <= i_q + 1'b1;
				end else begin
					j_q <= j_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q <= PW'(a);
			b_q <= PW'(b);
		end
		prod_s1 <= ca * cb;
		sum_s1 <= {1'b0, i_q} + {1'b0, j_q};
		if (start) begin
			acc_q <= '0;
		end else if (pv_s1) begin
			acc_q <= acc_q + (pp_ext << (sum_s1 * MUL_CHUNK_W));
		end
	end

	assign done = done_q;
	assign product = acc_q[2*W-1:0];

`ifndef ASSERT_OFF
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> !busy_q)
		else $error("multiplier started while busy");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> busy_q)
		else $error("multiplier did not begin after start");
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> (!busy_q && !pv_s1))
		else $error("product reported while partial products remain");
`endif

endmodule

`default_nettype wire

// File: rtl/core/einr_dp.sv
`default_nettype none
// ----------------------------------------------------------------------------
// einr_dp: bisection and power datapath
// Holds the search bounds, the square-and-multiply operands and the result
// register, and compares products against the radicand.
// ----------------------------------------------------------------------------
module einr_dp #(
	parameter int VALUE_WIDTH    = 32,
	parameter int EXPONENT_WIDTH = 8
) (
	input  wire logic                      clk,
	input  wire logic                      arst_n,
	input  wire einr_pkg::dp_cmd_t         cmd,
	input  wire logic [EXPONENT_WIDTH-1:0] exponent,
	input  wire logic [VALUE_WIDTH-1:0]    radicand,
	output einr_pkg::dp_stat_t             stat,
	output logic [einr_pkg::ROOT_W-1:0]    root,
	output logic                           found
);
	import einr_pkg::*;

	logic [EXPONENT_WIDTH-1:0] n_q;
	logic [EXPONENT_WIDTH-1:0] e_q;
	logic [VALUE_WIDTH-1:0]    m_q;
	logic [VALUE_WIDTH-1:0]    lo_q;
	logic [VALUE_WIDTH-1:0]    hi_q;
	logic [VALUE_WIDTH-1:0]    mid_q;
	logic [VALUE_WIDTH-1:0]    base_q;
	logic [VALUE_WIDTH-1:0]    acc_q;
	logic [VALUE_WIDTH-1:0]    res_root_q;
	logic                      res_found_q;
	logic [VALUE_WIDTH-1:0]    out_root_q;
	logic                      out_found_q;
	logic [VALUE_WIDTH-1:0]    mid;
	logic [VALUE_WIDTH-1:0]    mul_a;
	logic [2*VALUE_WIDTH-1:0]  product;
	logic                      mul_done;

	assign mid = lo_q + ((hi_q - lo_q) >> 1);
	assign mul_a = (cmd.mul_sel == MUL_SEL_ACC) ? acc_q : base_q;

	einr_mul #(
		.W(VALUE_WIDTH)
	) u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.start(cmd.mul_start),
		.a(mul_a),
		.b(base_q),
		.done(mul_done),
		.product(product)
	);

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q <= exponent;
			m_q <= radicand;
			lo_q <= VALUE_WIDTH'(1);
			hi_q <= radicand;
			res_root_q <= '0;
			res_found_q <= 1'b0;
		end
		if (cmd.setup) begin
			mid_q <= mid;
			base_q <= mid;
			acc_q <= VALUE_WIDTH'(1);
			e_q <= n_q;
		end
		if (cmd.acc_wr) begin
			acc_q <= product[VALUE_WIDTH-1:0];
		end
		if (cmd.base_wr) begin
			base_q <= product[VALUE_WIDTH-1:0];
		end
		if (cmd.e_shift) begin
			e_q <= e_q >> 1;
		end
		if (cmd.go_left) begin
			hi_q <= mid_q - 1'b1;
		end
		if (cmd.go_right) begin
			lo_q <= mid_q + 1'b1;
		end
		if (cmd.set_hit) begin
			res_root_q <= mid_q;
			res_found_q <= 1'b1;
		end
		if (cmd.out_load) begin
			out_root_q <= res_root_q;
			out_found_q <= res_found_q;
		end
	end

	always_comb begin
		stat.range_ok = (lo_q <= hi_q);
		stat.e_zero = (e_q == '0);
		stat.e_lsb = e_q[0];
		stat.e_last = ((e_q >> 1) == '0);
		stat.prod_gt = (product > (2*VALUE_WIDTH)'(m_q));
		stat.acc_eq = (acc_q == m_q);
		stat.mid_eq_hi = (mid_q == hi_q);
		stat.mul_done = mul_done;
	end

	assign root = ROOT_W'(out_root_q);
	assign found = out_found_q;

endmodule

`default_nettype wire

// File: rtl/core/einr_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// einr_ctrl: sequencing controller
// Steps the bisection loop and the square-and-multiply power test, and owns
// the input and output handshakes.
// ----------------------------------------------------------------------------
module einr_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	output logic                    out_valid,
	input  wire logic               out_stall,
	input  wire einr_pkg::dp_stat_t stat,
	output einr_pkg::dp_cmd_t       cmd
);
	import einr_pkg::*;

	state_t state_q;
	state_t state_d;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		cmd = '0;
		cmd.mul_sel = MUL_SEL_ACC;
		in_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = ST_RANGE;
				end
			end
			ST_RANGE: begin
				if (stat.range_ok) begin
					cmd.setup = 1'b1;
					state_d = ST_TEST;
				end else begin
					state_d = ST_FINISH;
				end
			end
			ST_TEST: begin
				if (stat.e_zero) begin
					state_d = ST_FINAL;
				end else if (stat.e_lsb) begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel = MUL_SEL_ACC;
					state_d = ST_WAIT_ACC;
				end else begin
					state_d = ST_SHIFT;
				end
			end
			ST_WAIT_ACC: begin
				if (stat.mul_done) begin
					if (stat.prod_gt) begin
						cmd.go_left = 1'b1;
						state_d = ST_RANGE;
					end else begin
						cmd.acc_wr = 1'b1;
						state_d = ST_SHIFT;
					end
				end
			end
			ST_SHIFT: begin
				cmd.e_shift = 1'b1;
				if (stat.e_last) begin
					state_d = ST_FINAL;
				end else begin
					cmd.mul_start = 1'b1;
					cmd.mul_sel = MUL_SEL_BASE;
					state_d = ST_WAIT_BASE;
				end
			end
			ST_WAIT_BASE: begin
				if (stat.mul_done) begin
					if (stat.prod_gt) begin
						cmd.go_left = 1'b1;
						state_d = ST_RANGE;
					end else begin
						cmd.base_wr = 1'b1;
						state_d = ST_TEST;
					end
				end
			end
			ST_FINAL: begin
				if (stat.acc_eq) begin
					cmd.set_hit = 1'b1;
					state_d = ST_FINISH;
				end else if (stat.mid_eq_hi) begin
					state_d = ST_FINISH;
				end else begin
					cmd.go_right = 1'b1;
					state_d = ST_RANGE;
				end
			end
			ST_FINISH: begin
				if (!out_valid_q || !out_stall) begin
					cmd.out_load = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

`ifndef ASSERT_OFF
	a_busy_after_in: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> in_stall)
		else $error("input taken while an item is in progress");
	a_load_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("result register overwritten before transfer");
	a_wait_mul: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.mul_start) |=> (state_q == ST_WAIT_ACC || state_q == ST_WAIT_BASE))
		else $error("multiply started outside a wait sequence");
`endif

endmodule

`default_nettype wire
